// ===== hw/rtl/first_fit_boundary_tag_allocator_macros.svh =====
// Assertion macros used by the allocator engine RTL.
`ifndef FIRST_FIT_BOUNDARY_TAG_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_BOUNDARY_TAG_ALLOCATOR_MACROS_SVH

// Same-cycle property, checked outside reset.
`define FFBT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define FFBT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/ffbt_pkg.sv =====
// Shared types and constants of the boundary-tag allocator.
`timescale 1ns / 1ps
`default_nettype none
package ffbt_pkg;

  localparam int HEAP_BYTES_DEF = 65536;
  localparam int OFS_W = 25;
  localparam int REQ_W = 32;
  localparam int IN_OFS_W = 16;
  localparam int OUT_OFS_W = 16;
  localparam int LIVE_W = 17;
  localparam int ALLOC_W = 32;
  localparam int BLK_W = 13;
  localparam int FREE_W = 16;
  localparam int HDR_BYTES = 8;
  localparam int MIN_BLOCK = 16;
  localparam int CMD_DEPTH = 2;
  localparam int RES_DEPTH = 2;

  localparam logic [1:0] REQ_ALLOC = 2'd0;
  localparam logic [1:0] REQ_RELEASE = 2'd1;
  localparam logic [1:0] REQ_PEAK = 2'd2;
  localparam logic [1:0] REQ_CENSUS = 2'd3;

  typedef struct packed {
    logic [1:0]           req_type;
    logic [REQ_W-1:0]     request_bytes;
    logic [IN_OFS_W-1:0]  payload_offset_in;
  } in_item_t;

  typedef struct packed {
    logic                 granted;
    logic [OUT_OFS_W-1:0] payload_offset_out;
    logic [LIVE_W-1:0]    live_byte_count;
    logic [LIVE_W-1:0]    peak_byte_count;
    logic [ALLOC_W-1:0]   allocations_made;
    logic [BLK_W-1:0]     blocks_in_use;
    logic [FREE_W-1:0]    free_byte_total;
    logic [FREE_W-1:0]    largest_free;
  } out_item_t;

  typedef enum logic [2:0] {
    OP_ALLOC,
    OP_RELEASE,
    OP_PEAK,
    OP_CENSUS,
    OP_REPLY
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [OFS_W-1:0] arg;
  } cmd_t;

  typedef enum logic [4:0] {
    S_INIT, S_IDLE,
    S_A_RD, S_A_SZ, S_A_NX, S_A_SPLIT, S_A_S1, S_A_S2, S_A_S3, S_A_DONE,
    S_L_RD, S_L_CHK, S_L_AFT, S_L_SET, S_L_PSZ, S_L_BEF, S_L_MRG, S_L_TAIL,
    S_C_RD, S_C_ACC, S_C_NX,
    S_R0, S_R1, S_R2, S_R3,
    S_P0, S_P1, S_P2,
    S_OUT
  } eng_state_t;

endpackage
`default_nettype wire

// ===== hw/rtl/ffbt_fifo.sv =====
// Small synchronous queue used between the allocator stages.
`timescale 1ns / 1ps
`default_nettype none
module ffbt_fifo #(
  parameter type ITEM_T = logic,
  parameter int DEPTH = ffbt_pkg::CMD_DEPTH
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  ITEM_T din,
  output logic  full,
  input  logic  pop,
  output ITEM_T dout,
  output logic  empty
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  ITEM_T slots [DEPTH];
  logic [PW-1:0] wp;
  logic [PW-1:0] rp;
  logic [CW-1:0] cnt;
  logic do_push;
  logic do_pop;

  assign full = (cnt == CW'(DEPTH));
  assign empty = (cnt == '0);
  assign do_push = push && !full;
  assign do_pop = pop && !empty;
  assign dout = slots[rp];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wp] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      cnt <= '0;
    end else begin
      if (do_push) begin
        wp <= (wp == PW'(DEPTH - 1)) ? '0 : wp + PW'(1);
      end
      if (do_pop) begin
        rp <= (rp == PW'(DEPTH - 1)) ? '0 : rp + PW'(1);
      end
      if (do_push && !do_pop) begin
        cnt <= cnt + CW'(1);
      end else if (do_pop && !do_push) begin
        cnt <= cnt - CW'(1);
      end
    end
  end
endmodule
`default_nettype wire

// ===== hw/rtl/ffbt_front.sv =====
// Request decoder: checks and classifies requests before they reach the engine.
`timescale 1ns / 1ps
`default_nettype none
module ffbt_front #(
  parameter int HEAP_BYTES = ffbt_pkg::HEAP_BYTES_DEF
) (
  input  ffbt_pkg::in_item_t request,
  output ffbt_pkg::cmd_t     cmd
);
  localparam logic [31:0] TOTAL = 32'((HEAP_BYTES / 8) * 8 - 8);

  logic [32:0] want_raw;
  logic [32:0] want;
  logic [31:0] blk;
  logic        bad_ptr;

  always_comb begin
    want_raw = {1'b0, request.request_bytes} + 33'(ffbt_pkg::HDR_BYTES + 7);
    want = want_raw & ~33'd7;
    if (want < 33'(ffbt_pkg::MIN_BLOCK)) begin
      want = 33'(ffbt_pkg::MIN_BLOCK);
    end
    blk = 32'(request.payload_offset_in) - 32'(ffbt_pkg::HDR_BYTES);
    bad_ptr = (request.payload_offset_in == '0) || (request.payload_offset_in[2:0] != 3'b000)
              || (blk >= TOTAL);
  end

  always_comb begin
    cmd.op = ffbt_pkg::OP_REPLY;
    cmd.arg = '0;
    case (request.req_type)
      ffbt_pkg::REQ_ALLOC: begin
        if (request.request_bytes <= TOTAL) begin
          cmd.op = ffbt_pkg::OP_ALLOC;
          cmd.arg = want[ffbt_pkg::OFS_W-1:0];
        end
      end
      ffbt_pkg::REQ_RELEASE: begin
        if (!bad_ptr) begin
          cmd.op = ffbt_pkg::OP_RELEASE;
          cmd.arg = blk[ffbt_pkg::OFS_W-1:0];
        end
      end
      ffbt_pkg::REQ_PEAK: begin
        cmd.op = ffbt_pkg::OP_PEAK;
      end
      ffbt_pkg::REQ_CENSUS: begin
        cmd.op = ffbt_pkg::OP_CENSUS;
      end
      default: begin
        cmd.op = ffbt_pkg::OP_REPLY;
      end
    endcase
  end
endmodule
`default_nettype wire

// ===== hw/rtl/ffbt_engine.sv =====
// Heap engine: word store, free-list sequencer and usage counters.
`timescale 1ns / 1ps
`default_nettype none
`include "first_fit_boundary_tag_allocator_macros.svh"
module ffbt_engine #(
  parameter int HEAP_BYTES = ffbt_pkg::HEAP_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_empty,
  input  ffbt_pkg::cmd_t      cmd,
  output logic                cmd_pop,
  input  logic                res_full,
  output logic                res_push,
  output ffbt_pkg::out_item_t res
);
  localparam int AW = $clog2(HEAP_BYTES + 1);
  localparam int HEAP_WORDS = HEAP_BYTES / 4;
  localparam int WA = $clog2(HEAP_WORDS);
  localparam logic [AW-1:0] TOTAL = AW'((HEAP_BYTES / 8) * 8 - 8);
  localparam logic [AW-1:0] NOB = AW'(HEAP_BYTES);
  localparam logic [AW-1:0] ONE = AW'(1);
  localparam logic [ffbt_pkg::BLK_W-1:0] BLK_ONE = ffbt_pkg::BLK_W'(1);

  ffbt_pkg::eng_state_t state, state_next, ret;

  logic [31:0] store [HEAP_WORDS];
  logic [31:0] mem_q;
  logic [AW-1:0] rd_off, wr_off;
  logic [31:0] wr_data;
  logic wr_en;

  logic [2:0] icnt;
  logic [AW-1:0] head, cur, sz, want, nb, nsz, rm, pb, nv, pv, ftot, flarge;
  logic gr;
  logic [ffbt_pkg::LIVE_W-1:0] live, peak, live_add;
  logic [ffbt_pkg::ALLOC_W-1:0] allocs;
  logic [ffbt_pkg::BLK_W-1:0] nblk;
  logic [AW-1:0] q_ofs, q_sz, rsz;
  logic split, res_valid;

  function automatic logic is_none(input logic [AW-1:0] x);
    return x >= NOB;
  endfunction

  // A neighbour whose header would fall outside the store counts as used.
  function automatic logic out_of_store(input logic [AW-1:0] x);
    return (x >= NOB) || ((x >> 2) + ONE >= AW'(HEAP_WORDS));
  endfunction

  assign q_ofs = mem_q[AW-1:0];
  assign q_sz = q_ofs & ~ONE;
  assign rsz = sz - want;
  assign split = rsz >= AW'(ffbt_pkg::MIN_BLOCK);
  assign live_add = live + ffbt_pkg::LIVE_W'(sz);

  always_ff @(posedge clk) begin
    if (wr_en && (wr_off < NOB)) begin
      store[wr_off[WA+1:2]] <= wr_data;
    end
    mem_q <= store[rd_off[WA+1:2]];
  end

  always_comb begin
    state_next = state;
    case (state)
      ffbt_pkg::S_INIT: if (icnt == 3'd5) state_next = ffbt_pkg::S_IDLE;
      ffbt_pkg::S_IDLE: begin
        if (!cmd_empty) begin
          case (cmd.op)
            ffbt_pkg::OP_ALLOC: state_next = ffbt_pkg::S_A_RD;
            ffbt_pkg::OP_RELEASE: state_next = ffbt_pkg::S_L_RD;
            ffbt_pkg::OP_CENSUS: state_next = ffbt_pkg::S_C_RD;
            default: state_next = ffbt_pkg::S_OUT;
          endcase
        end
      end
      ffbt_pkg::S_A_RD: state_next = is_none(cur) ? ffbt_pkg::S_OUT : ffbt_pkg::S_A_SZ;
      ffbt_pkg::S_A_SZ: state_next = (q_sz >= want) ? ffbt_pkg::S_R0 : ffbt_pkg::S_A_NX;
      ffbt_pkg::S_A_NX: state_next = is_none(q_ofs) ? ffbt_pkg::S_OUT : ffbt_pkg::S_A_SZ;
      ffbt_pkg::S_A_SPLIT: state_next = split ? ffbt_pkg::S_A_S1 : ffbt_pkg::S_A_DONE;
      ffbt_pkg::S_A_S1: state_next = ffbt_pkg::S_A_S2;
      ffbt_pkg::S_A_S2: state_next = ffbt_pkg::S_A_S3;
      ffbt_pkg::S_A_S3: state_next = ffbt_pkg::S_P0;
      ffbt_pkg::S_A_DONE: state_next = ffbt_pkg::S_OUT;
      ffbt_pkg::S_L_RD: state_next = ffbt_pkg::S_L_CHK;
      ffbt_pkg::S_L_CHK: state_next = mem_q[0] ? ffbt_pkg::S_L_AFT : ffbt_pkg::S_OUT;
      ffbt_pkg::S_L_AFT: begin
        state_next = (out_of_store(nb) || mem_q[0]) ? ffbt_pkg::S_L_SET : ffbt_pkg::S_R0;
      end
      ffbt_pkg::S_L_SET: state_next = ffbt_pkg::S_L_PSZ;
      ffbt_pkg::S_L_PSZ: begin
        state_next = ((mem_q != '0) && (mem_q <= 32'(cur))) ? ffbt_pkg::S_L_BEF
                                                            : ffbt_pkg::S_L_TAIL;
      end
      ffbt_pkg::S_L_BEF: begin
        state_next = (out_of_store(nb) || mem_q[0]) ? ffbt_pkg::S_L_TAIL : ffbt_pkg::S_R0;
      end
      ffbt_pkg::S_L_MRG: state_next = ffbt_pkg::S_L_TAIL;
      ffbt_pkg::S_L_TAIL: state_next = ffbt_pkg::S_P0;
      ffbt_pkg::S_C_RD: state_next = is_none(cur) ? ffbt_pkg::S_OUT : ffbt_pkg::S_C_ACC;
      ffbt_pkg::S_C_ACC: state_next = ffbt_pkg::S_C_NX;
      ffbt_pkg::S_C_NX: state_next = is_none(q_ofs) ? ffbt_pkg::S_OUT : ffbt_pkg::S_C_ACC;
      ffbt_pkg::S_R0: state_next = ffbt_pkg::S_R1;
      ffbt_pkg::S_R1: state_next = ffbt_pkg::S_R2;
      ffbt_pkg::S_R2: state_next = ffbt_pkg::S_R3;
      ffbt_pkg::S_R3: state_next = ret;
      ffbt_pkg::S_P0: state_next = ffbt_pkg::S_P1;
      ffbt_pkg::S_P1: state_next = ffbt_pkg::S_P2;
      ffbt_pkg::S_P2: state_next = ret;
      ffbt_pkg::S_OUT: if (!res_full) state_next = ffbt_pkg::S_IDLE;
      default: state_next = ffbt_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    rd_off = '0;
    wr_en = 1'b0;
    wr_off = '0;
    wr_data = '0;
    cmd_pop = 1'b0;
    res_valid = 1'b0;
    case (state)
      ffbt_pkg::S_INIT: begin
        wr_en = 1'b1;
        case (icnt)
          3'd0: begin wr_off = '0; wr_data = 32'(TOTAL); end
          3'd1: begin wr_off = AW'(4); wr_data = '0; end
          3'd2: begin wr_off = AW'(8); wr_data = 32'(NOB); end
          3'd3: begin wr_off = AW'(12); wr_data = 32'(NOB); end
          3'd4: begin wr_off = TOTAL; wr_data = 32'(ffbt_pkg::HDR_BYTES + 1); end
          default: begin wr_off = TOTAL + AW'(4); wr_data = 32'(TOTAL); end
        endcase
      end
      ffbt_pkg::S_IDLE: cmd_pop = !cmd_empty;
      ffbt_pkg::S_A_RD: rd_off = cur;
      ffbt_pkg::S_A_SZ: rd_off = cur + AW'(8);
      ffbt_pkg::S_A_NX: rd_off = q_ofs;
      ffbt_pkg::S_A_SPLIT: begin
        wr_en = 1'b1;
        if (split) begin
          wr_off = cur + want;
          wr_data = 32'(rsz);
        end else begin
          wr_off = cur;
          wr_data = 32'(sz | ONE);
        end
      end
      ffbt_pkg::S_A_S1: begin
        wr_en = 1'b1;
        wr_off = cur + want + AW'(4);
        wr_data = 32'(want);
      end
      ffbt_pkg::S_A_S2: begin
        wr_en = 1'b1;
        wr_off = cur + sz + AW'(4);
        wr_data = 32'(rsz);
      end
      ffbt_pkg::S_A_S3: begin
        wr_en = 1'b1;
        wr_off = cur;
        wr_data = 32'(want | ONE);
      end
      ffbt_pkg::S_L_RD: rd_off = cur;
      ffbt_pkg::S_L_CHK: begin
        wr_en = mem_q[0];
        wr_off = cur;
        wr_data = 32'(q_sz);
        rd_off = cur + q_sz;
      end
      ffbt_pkg::S_L_SET: begin
        wr_en = 1'b1;
        wr_off = cur;
        wr_data = 32'(sz);
        rd_off = cur + AW'(4);
      end
      ffbt_pkg::S_L_PSZ: rd_off = cur - q_ofs;
      ffbt_pkg::S_L_MRG: begin
        wr_en = 1'b1;
        wr_off = nb;
        wr_data = 32'(nsz + sz);
      end
      ffbt_pkg::S_L_TAIL: begin
        wr_en = 1'b1;
        wr_off = cur + sz + AW'(4);
        wr_data = 32'(sz);
      end
      ffbt_pkg::S_C_RD: rd_off = cur;
      ffbt_pkg::S_C_ACC: rd_off = cur + AW'(8);
      ffbt_pkg::S_C_NX: rd_off = q_ofs;
      ffbt_pkg::S_R0: rd_off = rm + AW'(8);
      ffbt_pkg::S_R1: rd_off = rm + AW'(12);
      ffbt_pkg::S_R2: begin
        wr_en = !is_none(q_ofs);
        wr_off = q_ofs + AW'(8);
        wr_data = 32'(nv);
      end
      ffbt_pkg::S_R3: begin
        wr_en = !is_none(nv);
        wr_off = nv + AW'(12);
        wr_data = 32'(pv);
      end
      ffbt_pkg::S_P0: begin
        wr_en = 1'b1;
        wr_off = pb + AW'(12);
        wr_data = 32'(NOB);
      end
      ffbt_pkg::S_P1: begin
        wr_en = 1'b1;
        wr_off = pb + AW'(8);
        wr_data = 32'(head);
      end
      ffbt_pkg::S_P2: begin
        wr_en = !is_none(head);
        wr_off = head + AW'(12);
        wr_data = 32'(pb);
      end
      ffbt_pkg::S_OUT: res_valid = 1'b1;
      default: begin
        rd_off = '0;
      end
    endcase
  end

  assign res_push = res_valid && !res_full;

  always_comb begin
    res.granted = gr;
    res.payload_offset_out = gr ? ffbt_pkg::OUT_OFS_W'(cur + AW'(8)) : '0;
    res.live_byte_count = live;
    res.peak_byte_count = peak;
    res.allocations_made = allocs;
    res.blocks_in_use = nblk;
    res.free_byte_total = ffbt_pkg::FREE_W'(ftot);
    res.largest_free = ffbt_pkg::FREE_W'(flarge);
  end

  // Datapath registers; the remove and push subroutines return through ret.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ffbt_pkg::S_INIT;
      ret <= ffbt_pkg::S_IDLE;
      icnt <= '0;
      head <= '0;
      live <= '0;
      peak <= '0;
      allocs <= '0;
      nblk <= '0;
      gr <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        ffbt_pkg::S_INIT: icnt <= icnt + 3'd1;
        ffbt_pkg::S_IDLE: begin
          if (!cmd_empty) begin
            gr <= 1'b0;
            ftot <= '0;
            flarge <= '0;
            want <= cmd.arg[AW-1:0];
            cur <= (cmd.op == ffbt_pkg::OP_RELEASE) ? cmd.arg[AW-1:0] : head;
            if (cmd.op == ffbt_pkg::OP_PEAK) begin
              peak <= live;
              allocs <= '0;
            end
          end
        end
        ffbt_pkg::S_A_SZ: begin
          if (q_sz >= want) begin
            sz <= q_sz;
            rm <= cur;
            ret <= ffbt_pkg::S_A_SPLIT;
          end
        end
        ffbt_pkg::S_A_NX: cur <= q_ofs;
        ffbt_pkg::S_A_SPLIT: ;
        ffbt_pkg::S_A_S3: begin
          sz <= want;
          pb <= cur + want;
          ret <= ffbt_pkg::S_A_DONE;
        end
        ffbt_pkg::S_A_DONE: begin
          gr <= 1'b1;
          live <= live_add;
          if (live_add > peak) begin
            peak <= live_add;
          end
          allocs <= allocs + ffbt_pkg::ALLOC_W'(1);
          nblk <= nblk + BLK_ONE;
        end
        ffbt_pkg::S_L_CHK: begin
          if (mem_q[0]) begin
            sz <= q_sz;
            nb <= cur + q_sz;
            live <= live - ffbt_pkg::LIVE_W'(q_sz);
            nblk <= nblk - BLK_ONE;
          end
        end
        ffbt_pkg::S_L_AFT: begin
          if (!(out_of_store(nb) || mem_q[0])) begin
            sz <= sz + q_sz;
            rm <= nb;
            ret <= ffbt_pkg::S_L_SET;
          end
        end
        ffbt_pkg::S_L_PSZ: nb <= cur - q_ofs;
        ffbt_pkg::S_L_BEF: begin
          nsz <= q_sz;
          rm <= nb;
          ret <= ffbt_pkg::S_L_MRG;
        end
        ffbt_pkg::S_L_MRG: begin
          cur <= nb;
          sz <= nsz + sz;
        end
        ffbt_pkg::S_L_TAIL: begin
          pb <= cur;
          ret <= ffbt_pkg::S_OUT;
        end
        ffbt_pkg::S_C_ACC: begin
          ftot <= ftot + q_sz;
          if (q_sz > flarge) begin
            flarge <= q_sz;
          end
        end
        ffbt_pkg::S_C_NX: cur <= q_ofs;
        ffbt_pkg::S_R1: nv <= q_ofs;
        ffbt_pkg::S_R2: begin
          pv <= q_ofs;
          if (is_none(q_ofs)) begin
            head <= nv;
          end
        end
        ffbt_pkg::S_P2: head <= pb;
        default: ;
      endcase
    end
  end

  `FFBT_ASSERT(a_head_aligned, (head >= NOB) || (head[2:0] == 3'b000), "free-list head misaligned")
  `FFBT_ASSERT(a_idle_no_write, (state != ffbt_pkg::S_IDLE) || !wr_en, "store written while idle")
  `FFBT_ASSERT_NEXT(a_push_idle, res_push, state == ffbt_pkg::S_IDLE, "engine busy after result")
  `FFBT_ASSERT_NEXT(a_alloc_count, state == ffbt_pkg::S_A_DONE, nblk == $past(nblk) + BLK_ONE, "block count not advanced")
endmodule
`default_nettype wire

// ===== hw/rtl/first_fit_boundary_tag_allocator.sv =====
// Top level of the first-fit boundary-tag heap allocator.
//
//   channel   handshake          payload
//   request   push / full        request (in_item_t)
//   result    pop / empty        result (out_item_t)
//
// Engine work per transaction: an allocate walks the free list to the first fit and
// takes the block whole or splits it. A release frees the block and merges it with
// the neighbours above and below when they are free. A census walks the free list.
// Peak reset and refused requests go straight to the result; so does a release of
// a block not in use. After rst the engine writes the initial block and sentinel;
// requests queue meanwhile. A full result queue stalls the engine, not the decoder.
`timescale 1ns / 1ps
`default_nettype none
module first_fit_boundary_tag_allocator #(
  parameter int HEAP_BYTES = ffbt_pkg::HEAP_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  ffbt_pkg::in_item_t  request,
  output logic                empty,
  input  logic                pop,
  output ffbt_pkg::out_item_t result
);
  ffbt_pkg::cmd_t cmd_in, cmd_out;
  ffbt_pkg::out_item_t res;
  logic cmd_empty, cmd_pop, res_full, res_push;

  ffbt_front #(.HEAP_BYTES(HEAP_BYTES)) u_front (
    .request(request),
    .cmd(cmd_in)
  );

  ffbt_fifo #(.ITEM_T(ffbt_pkg::cmd_t), .DEPTH(ffbt_pkg::CMD_DEPTH)) u_cmd_q (
    .clk(clk), .rst(rst),
    .push(push), .din(cmd_in), .full(full),
    .pop(cmd_pop), .dout(cmd_out), .empty(cmd_empty)
  );

  ffbt_engine #(.HEAP_BYTES(HEAP_BYTES)) u_engine (
    .clk(clk), .rst(rst),
    .cmd_empty(cmd_empty), .cmd(cmd_out), .cmd_pop(cmd_pop),
    .res_full(res_full), .res_push(res_push), .res(res)
  );

  ffbt_fifo #(.ITEM_T(ffbt_pkg::out_item_t), .DEPTH(ffbt_pkg::RES_DEPTH)) u_res_q (
    .clk(clk), .rst(rst),
    .push(res_push), .din(res), .full(res_full),
    .pop(pop), .dout(result), .empty(empty)
  );
endmodule
`default_nettype wire

// ===== tb/ffbt_checker.sv =====
// Checker for the boundary-tag allocator: predicts every result and compares it.
`timescale 1ns / 1ps
module ffbt_checker (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  logic                full,
  input  ffbt_pkg::in_item_t  request,
  input  logic                empty,
  input  logic                pop,
  input  ffbt_pkg::out_item_t result,
  output int                  fail_count,
  output int                  pending_count
);
  import ffbt_pkg::*;

  localparam int HB = HEAP_BYTES_DEF;
  localparam int WORDS = HB / 4;
  localparam logic [31:0] TOTAL = (HB & ~7) - 8;
  localparam logic [31:0] NONE = HB;
  localparam int WALK = HB / 16 + 1;

  logic [31:0] mem [WORDS];
  logic [31:0] head, live, peak, tally, blocks;
  out_item_t   expected_results [$];

  function automatic logic [31:0] rd(logic [31:0] off);
    return ((off >> 2) < WORDS) ? mem[off >> 2] : 32'd0;
  endfunction

  function automatic void wr(logic [31:0] off, logic [31:0] v);
    if ((off >> 2) < WORDS) mem[off >> 2] = v;
  endfunction

  function automatic bit is_used(logic [31:0] b);
    if (b >= HB || (b >> 2) + 1 >= WORDS) return 1'b1;
    return (rd(b) & 32'd1) != 32'd0;
  endfunction

  function automatic void unlink(logic [31:0] b);
    logic [31:0] n, p;
    n = rd(b + 8);
    p = rd(b + 12);
    if (p < HB) wr(p + 8, n);
    else head = n;
    if (n < HB) wr(n + 12, p);
  endfunction

  function automatic void link(logic [31:0] b);
    wr(b + 12, NONE);
    wr(b + 8, head);
    if (head < HB) wr(head + 12, b);
    head = b;
  endfunction

  task automatic heap_init();
    for (int i = 0; i < WORDS; i++) mem[i] = 0;
    wr(0, TOTAL);
    wr(4, 0);
    wr(TOTAL, 32'd9);
    wr(TOTAL + 4, TOTAL);
    head = NONE;
    link(0);
    live = 0; peak = 0; tally = 0; blocks = 0;
  endtask

  function automatic logic [31:0] grant(logic [31:0] req);
    logic [31:0] want, b, avail, rem, rsz;
    if (req > TOTAL) return 0;
    want = (req + 15) & ~32'd7;
    if (want < MIN_BLOCK) want = MIN_BLOCK;
    b = head;
    for (int s = 0; b < HB && s < WALK; s++) begin
      avail = rd(b) & ~32'd1;
      if (avail >= want) begin
        unlink(b);
        if (avail - want >= MIN_BLOCK) begin
          rem = b + want;
          rsz = avail - want;
          wr(rem, rsz);
          wr(rem + 4, want);
          wr(rem + rsz + 4, rsz);
          wr(b, want);
          link(rem);
        end
        wr(b, rd(b) | 1);
        live = (live + (rd(b) & ~32'd1)) & 32'h1FFFF;
        if (live > peak) peak = live;
        tally++;
        blocks = (blocks + 1) & 32'h1FFF;
        return b + 8;
      end
      b = rd(b + 8);
    end
    return 0;
  endfunction

  function automatic void give_back(logic [31:0] p);
    logic [31:0] b, sz, after, psz, prior;
    if (p == 0 || p[2:0] != 0) return;
    b = p - 8;
    if (b >= TOTAL || (rd(b) & 32'd1) == 32'd0) return;
    sz = rd(b) & ~32'd1;
    live = (live - sz) & 32'h1FFFF;
    blocks = (blocks - 1) & 32'h1FFF;
    wr(b, sz);
    after = b + sz;
    if (!is_used(after)) begin
      unlink(after);
      wr(b, rd(b) + (rd(after) & ~32'd1));
    end
    psz = rd(b + 4);
    if (psz != 0 && psz <= b) begin
      prior = b - psz;
      if (!is_used(prior)) begin
        unlink(prior);
        wr(prior, rd(prior) + rd(b));
        b = prior;
      end
    end
    wr(b + rd(b) + 4, rd(b));
    link(b);
  endfunction

  function automatic out_item_t predict(in_item_t it);
    out_item_t r;
    logic [31:0] off, ft, fl, b, s;
    off = 0; ft = 0; fl = 0;
    case (it.req_type)
      REQ_ALLOC: off = grant(it.request_bytes);
      REQ_RELEASE: give_back({16'd0, it.payload_offset_in});
      REQ_PEAK: begin
        peak = live;
        tally = 0;
      end
      default: begin
        b = head;
        for (int k = 0; b < HB && k < WALK; k++) begin
          s = rd(b) & ~32'd1;
          ft += s;
          if (s > fl) fl = s;
          b = rd(b + 8);
        end
      end
    endcase
    r.granted = (off != 0);
    r.payload_offset_out = off[15:0];
    r.live_byte_count = live[16:0];
    r.peak_byte_count = peak[16:0];
    r.allocations_made = tally;
    r.blocks_in_use = blocks[12:0];
    r.free_byte_total = ft[15:0];
    r.largest_free = fl[15:0];
    return r;
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    heap_init();
  end

  assign pending_count = expected_results.size();

  always @(posedge clk) begin
    out_item_t e;
    if (!rst) begin
      if (push && !full) expected_results.push_back(predict(request));
      if (pop && !empty) begin
        if (expected_results.size() == 0) begin
          report("unexpected result", 64'(result.payload_offset_out), 64'd0);
        end else begin
          e = expected_results.pop_front();
          if (result.granted !== e.granted)
            report("granted", 64'(result.granted), 64'(e.granted));
          if (result.payload_offset_out !== e.payload_offset_out)
            report("payload_offset_out", 64'(result.payload_offset_out),
                   64'(e.payload_offset_out));
          if (result.live_byte_count !== e.live_byte_count)
            report("live_byte_count", 64'(result.live_byte_count), 64'(e.live_byte_count));
          if (result.peak_byte_count !== e.peak_byte_count)
            report("peak_byte_count", 64'(result.peak_byte_count), 64'(e.peak_byte_count));
          if (result.allocations_made !== e.allocations_made)
            report("allocations_made", 64'(result.allocations_made),
                   64'(e.allocations_made));
          if (result.blocks_in_use !== e.blocks_in_use)
            report("blocks_in_use", 64'(result.blocks_in_use), 64'(e.blocks_in_use));
          if (result.free_byte_total !== e.free_byte_total)
            report("free_byte_total", 64'(result.free_byte_total), 64'(e.free_byte_total));
          if (result.largest_free !== e.largest_free)
            report("largest_free", 64'(result.largest_free), 64'(e.largest_free));
        end
      end
    end
  end
endmodule

// ===== tb/tb_top.sv =====
// Testbench top: drives allocator requests, pops results and reports the verdict.
`timescale 1ns / 1ps
module tb_top;
  import ffbt_pkg::*;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      push = 1'b0;
  logic      pop = 1'b0;
  logic      full, empty;
  in_item_t  request = '0;
  out_item_t result;
  int        fail_count, pending_count;
  int        cycles = 0;
  bit        hold_pop = 1'b0;
  bit        stim_done = 1'b0;
  logic [15:0] live_ptrs [$];

  first_fit_boundary_tag_allocator dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .request(request),
    .empty(empty), .pop(pop), .result(result)
  );

  ffbt_checker chk (
    .clk(clk), .rst(rst), .push(push), .full(full), .request(request),
    .empty(empty), .pop(pop), .result(result),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Track granted pointers so releases name live payloads, never stale ones.
  always @(posedge clk) begin
    if (!rst && pop && !empty && result.granted)
      live_ptrs.push_back(result.payload_offset_out);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > 20000000) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Push stays high between back-to-back transactions; an idle gap or drain() lowers it.
  task automatic send(logic [1:0] kind, logic [31:0] bytes, logic [15:0] ofs, bit gap);
    int idle;
    idle = gap ? $urandom_range(0, 11) : 0;
    if (idle != 0) begin
      push <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    request <= '{req_type: kind, request_bytes: bytes, payload_offset_in: ofs};
    push <= 1'b1;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  // A release of a live payload; the pointer leaves the pool when the release is sent.
  task automatic send_release(bit gap);
    int k;
    logic [15:0] p;
    if (live_ptrs.size() == 0) begin
      send(REQ_RELEASE, $urandom, 16'd0, gap);
    end else begin
      k = $urandom_range(0, live_ptrs.size() - 1);
      p = live_ptrs[k];
      live_ptrs.delete(k);
      send(REQ_RELEASE, $urandom, p, gap);
    end
  endtask

  task automatic drain();
    push <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(0, 200);
    if (r < 90) return $urandom_range(0, 4000);
    if (r < 97) return $urandom_range(0, 65528);
    return $urandom;
  endfunction

  always @(posedge clk) begin
    int idle;
    if (rst) begin
      pop <= 1'b0;
    end else if (hold_pop) begin
      pop <= 1'b0;
    end else if (pop && !empty) begin
      idle = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 11) : 0;
      if (idle != 0) begin
        pop <= 1'b0;
        repeat (idle - 1) @(posedge clk);
        pop <= 1'b1;
      end
    end else begin
      pop <= 1'b1;
    end
  end

  initial begin
    int r;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    // Directed: extremes, every request kind and the named corner cases.
    send(REQ_CENSUS, 0, 0, 0);
    send(REQ_ALLOC, 32'hFFFF_FFFF, 0, 0);
    send(REQ_ALLOC, 65529, 0, 0);
    send(REQ_ALLOC, 0, 16'hFFFF, 0);
    send(REQ_ALLOC, 1, 0, 0);
    send(REQ_ALLOC, 9, 0, 0);
    send(REQ_RELEASE, 0, 16'd0, 0);
    send(REQ_RELEASE, 0, 16'd13, 0);
    send(REQ_RELEASE, 0, 16'hFFF8, 0);
    send(REQ_RELEASE, 0, 16'd64, 0);
    send(REQ_CENSUS, 0, 0, 0);
    drain();
    send_release(0);
    send(REQ_PEAK, 32'hFFFF_FFFF, 16'hFFFF, 0);
    send_release(0);
    send(REQ_CENSUS, 0, 0, 0);
    send(REQ_ALLOC, 65528, 0, 0);
    drain();
    send_release(0);
    send(REQ_ALLOC, 65520, 0, 0);
    send(REQ_CENSUS, 0, 0, 0);
    drain();
    while (live_ptrs.size() != 0) send_release(1);
    send(REQ_CENSUS, 0, 0, 0);
    drain();
    // Hold the result side off so the request queue fills and stalls.
    fork
      begin
        hold_pop = 1'b1;
        repeat (300) @(posedge clk);
        hold_pop = 1'b0;
      end
      for (int i = 0; i < 20; i++) send(REQ_ALLOC, $urandom_range(0, 64), 0, 0);
    join
    drain();
    for (int i = 0; i < 1020; i++) begin
      r = $urandom_range(0, 99);
      if (i == 500) drain();
      if (r < 45) send(REQ_ALLOC, pick_size(), 16'($urandom), i % 40 < 30);
      else if (r < 85) send_release(i % 40 < 30);
      // Random release pointers are kept misaligned so they never free a pooled block.
      else if (r < 88) send(REQ_RELEASE, $urandom, 16'($urandom) | 16'd4, 1);
      else if (r < 92) send(REQ_PEAK, $urandom, 16'($urandom), 1);
      else send(REQ_CENSUS, $urandom, 16'($urandom), 1);
      // Pointers granted while the pool was empty show up once results arrive.
      if (live_ptrs.size() == 0 && r >= 45 && r < 85) drain();
    end
    drain();
    repeat (200) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

// ===== first_fit_boundary_tag_allocator.f =====
+incdir+hw/rtl
hw/rtl/ffbt_pkg.sv
hw/rtl/ffbt_fifo.sv
hw/rtl/ffbt_front.sv
hw/rtl/ffbt_engine.sv
hw/rtl/first_fit_boundary_tag_allocator.sv
tb/ffbt_checker.sv
tb/tb_top.sv
